// ===== hdl/cfbp_pkg.sv =====
// package for the can frame bit packer: widths, codes, word and control types
// no dependencies
package cfbp_pkg;

    localparam int DATA_BYTES     = 8;
    localparam int MAX_FIELD_BITS = 32;
    localparam int FRAME_BYTES    = 8;
    localparam int ID_BITS_EXT    = 29;
    localparam int ID_BITS_STD    = 11;
    localparam int BYTE_BITS      = 8;

    localparam int ID_W    = 29;
    localparam int FIELD_W = 32;
    localparam int CNT_W   = 6;
    localparam int DATA_W  = FRAME_BYTES * BYTE_BITS;
    localparam int LEN_W   = 4;
    localparam int CUR_W   = 7;
    localparam int IDS_W   = 5;
    localparam int IDX_W   = 3;

    typedef enum logic [1:0] {
        KIND_WRITE  = 2'd0,
        KIND_READ   = 2'd1,
        KIND_REWIND = 2'd2,
        KIND_LOAD   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } state_t;

    typedef struct packed {
        kind_t              kind;
        logic [FIELD_W-1:0] field_value;
        logic [CNT_W-1:0]   bit_count;
        logic [ID_W-1:0]    load_id;
        logic [DATA_W-1:0]  load_data;
        logic [LEN_W-1:0]   load_len;
    } in_word_t;

    typedef struct packed {
        logic [FIELD_W-1:0] read_value;
        logic [ID_W-1:0]    frame_id;
        logic [DATA_W-1:0]  frame_data;
        logic [LEN_W-1:0]   frame_len;
        logic [CUR_W-1:0]   bits_used;
        logic               overflow;
    } out_word_t;

    typedef struct packed {
        logic in_ready;
        logic walk_en;
        logic finish;
    } ctrl_t;

    typedef struct packed {
        logic               in_id;
        logic [IDX_W-1:0]   byte_idx;
        logic [CNT_W-1:0]   take;
        logic [ID_W-1:0]    new_unit;
        logic [FIELD_W-1:0] read_bits;
    } chunk_t;

endpackage

// ===== hdl/cfbp_chunk.sv =====
// shared chunk unit: moves one field chunk between the word and the unit under the cursor
// depends on cfbp_pkg
module cfbp_chunk
(
    input  logic                           ext,
    input  logic [cfbp_pkg::CUR_W-1:0]     cursor,
    input  logic [cfbp_pkg::CNT_W-1:0]     remaining,
    input  logic [cfbp_pkg::FIELD_W-1:0]   value,
    input  logic [cfbp_pkg::ID_W-1:0]      id_data,
    input  logic [cfbp_pkg::DATA_W-1:0]    frame_data,
    output cfbp_pkg::chunk_t               chunk
);

    logic [cfbp_pkg::IDS_W-1:0]   ids;
    logic                         in_id;
    logic [cfbp_pkg::CUR_W-1:0]   off;
    logic [cfbp_pkg::IDS_W-1:0]   free_bits;
    logic [cfbp_pkg::CNT_W-1:0]   take;
    logic [cfbp_pkg::IDS_W-1:0]   dst;
    logic [cfbp_pkg::CNT_W-1:0]   src;
    logic [cfbp_pkg::FIELD_W-1:0] mask;
    logic [cfbp_pkg::FIELD_W-1:0] wbits;
    logic [cfbp_pkg::FIELD_W-1:0] wshift;
    logic [cfbp_pkg::IDX_W-1:0]   idx;
    logic [cfbp_pkg::ID_W-1:0]    unit;
    logic [cfbp_pkg::ID_W-1:0]    rbits;

    assign ids   = ext ? cfbp_pkg::IDS_W'(cfbp_pkg::ID_BITS_EXT)
                       : cfbp_pkg::IDS_W'(cfbp_pkg::ID_BITS_STD);
    assign in_id = cursor < {2'b00, ids};
    assign off   = cursor - {2'b00, ids};
    assign idx   = off[5:3];

    assign free_bits = in_id ? (ids - cursor[cfbp_pkg::IDS_W-1:0])
                             : (5'd8 - {2'b00, off[2:0]});
    assign take = ({1'b0, free_bits} < remaining) ? {1'b0, free_bits} : remaining;
    assign dst  = free_bits - take[cfbp_pkg::IDS_W-1:0];
    assign src  = remaining - take;
    assign mask = (32'd1 << take) - 32'd1;

    assign unit = in_id ? id_data : {21'd0, frame_data[{~idx, 3'b000} +: 8]};

    // write path: field bits aligned to the free slot
    assign wbits  = (value >> src) & mask;
    assign wshift = wbits << dst;

    // read path: slot bits aligned to their place in the field
    assign rbits = (unit >> dst) & mask[cfbp_pkg::ID_W-1:0];

    always_comb
    begin
        chunk.in_id     = in_id;
        chunk.byte_idx  = idx;
        chunk.take      = take;
        chunk.new_unit  = unit | wshift[cfbp_pkg::ID_W-1:0];
        chunk.read_bits = {3'b000, rbits} << src;
    end

endmodule

// ===== hdl/cfbp_seq.sv =====
// sequencer: idle, chunk walk, result hand-off
// depends on cfbp_pkg
module cfbp_seq
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            needs_walk,
    input  logic            last_chunk,
    input  logic            out_free,
    output cfbp_pkg::ctrl_t ctrl
);

    cfbp_pkg::state_t st_reg;
    cfbp_pkg::state_t st_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= cfbp_pkg::ST_IDLE;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            cfbp_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    st_next = needs_walk ? cfbp_pkg::ST_WALK : cfbp_pkg::ST_FINISH;
                end
            end
            cfbp_pkg::ST_WALK:
            begin
                if (last_chunk)
                begin
                    st_next = cfbp_pkg::ST_FINISH;
                end
            end
            cfbp_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    st_next = cfbp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                st_next = cfbp_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl.in_ready = (st_reg == cfbp_pkg::ST_IDLE);
        ctrl.walk_en  = (st_reg == cfbp_pkg::ST_WALK);
        ctrl.finish   = (st_reg == cfbp_pkg::ST_FINISH) && out_free;
    end

endmodule

// ===== hdl/can_frame_bit_packer_unit.sv =====
// top level of the can frame bit packer: frame image, cursor, output register
// depends on cfbp_pkg, cfbp_chunk, cfbp_seq
//
//  channel   direction  handshake            word
//  in        into       in_valid/in_ready    cfbp_pkg::in_word_t
//  out       out of     out_valid/out_ready  cfbp_pkg::out_word_t
//  cfg       into       cfg_we               extended_id
//
// write or read of n bits: one chunk per cycle through the chunk unit in the walk state,
// at most 5 chunks for 32 bits; all other words and rejected requests skip the walk state
// reset clears the frame image, length, cursor and extended_id
// a full output register holds the finished word until out_ready; the next word is
// accepted meanwhile, and its result waits in the hand-off state
module can_frame_bit_packer_unit
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  cfbp_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output cfbp_pkg::out_word_t out_data,
    input  logic                cfg_we,
    input  logic                cfg_wdata
);

    logic                         ext_reg;
    logic                         ext_next;
    logic [cfbp_pkg::ID_W-1:0]    id_reg;
    logic [cfbp_pkg::ID_W-1:0]    id_next;
    logic [cfbp_pkg::DATA_W-1:0]  data_reg;
    logic [cfbp_pkg::DATA_W-1:0]  data_next;
    logic [cfbp_pkg::LEN_W-1:0]   len_reg;
    logic [cfbp_pkg::LEN_W-1:0]   len_next;
    logic [cfbp_pkg::CUR_W-1:0]   cursor_reg;
    logic [cfbp_pkg::CUR_W-1:0]   cursor_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;

    cfbp_pkg::kind_t              kind_reg;
    cfbp_pkg::kind_t              kind_next;
    logic [cfbp_pkg::FIELD_W-1:0] fval_reg;
    logic [cfbp_pkg::FIELD_W-1:0] fval_next;
    logic [cfbp_pkg::CNT_W-1:0]   rem_reg;
    logic [cfbp_pkg::CNT_W-1:0]   rem_next;
    logic [cfbp_pkg::FIELD_W-1:0] acc_reg;
    logic [cfbp_pkg::FIELD_W-1:0] acc_next;
    logic                         ovf_reg;
    logic                         ovf_next;
    cfbp_pkg::out_word_t          out_reg;
    cfbp_pkg::out_word_t          out_next;

    cfbp_pkg::ctrl_t              ctrl;
    cfbp_pkg::chunk_t             chunk;

    logic                         accept;
    logic                         is_field;
    logic [cfbp_pkg::IDS_W-1:0]   ids;
    logic [cfbp_pkg::CUR_W-1:0]   total;
    logic [cfbp_pkg::CUR_W:0]     req_end;
    logic                         ovf;
    logic                         needs_walk;
    logic                         last_chunk;
    logic                         out_free;
    logic [cfbp_pkg::CUR_W-1:0]   new_cursor;
    logic [cfbp_pkg::CUR_W-1:0]   byte_off;
    logic [cfbp_pkg::LEN_W-1:0]   raw_len;
    logic [cfbp_pkg::LEN_W-1:0]   write_len;
    logic [cfbp_pkg::LEN_W-1:0]   load_len;

    assign accept   = in_valid && ctrl.in_ready;
    assign out_free = !out_valid_reg || out_ready;

    assign ids   = ext_reg ? cfbp_pkg::IDS_W'(cfbp_pkg::ID_BITS_EXT)
                           : cfbp_pkg::IDS_W'(cfbp_pkg::ID_BITS_STD);
    assign total = {2'b00, ids} + cfbp_pkg::CUR_W'(cfbp_pkg::BYTE_BITS * cfbp_pkg::DATA_BYTES);

    assign is_field   = (in_data.kind == cfbp_pkg::KIND_WRITE)
                     || (in_data.kind == cfbp_pkg::KIND_READ);
    assign req_end    = {1'b0, cursor_reg} + {2'b00, in_data.bit_count};
    assign ovf        = is_field
                     && ((in_data.bit_count > cfbp_pkg::CNT_W'(cfbp_pkg::MAX_FIELD_BITS))
                      || (req_end > {1'b0, total}));
    assign needs_walk = is_field && !ovf && (in_data.bit_count != '0);

    assign last_chunk = (rem_reg == chunk.take);
    assign new_cursor = cursor_reg + {1'b0, chunk.take};

    // length after a write: one more than the index of the byte under the cursor, saturated
    assign byte_off  = new_cursor - {2'b00, ids};
    assign raw_len   = byte_off[6:3] + 4'd1;
    assign write_len = (new_cursor < {2'b00, ids}) ? '0
                     : (raw_len > cfbp_pkg::LEN_W'(cfbp_pkg::DATA_BYTES))
                       ? cfbp_pkg::LEN_W'(cfbp_pkg::DATA_BYTES) : raw_len;
    assign load_len  = (in_data.load_len > cfbp_pkg::LEN_W'(cfbp_pkg::FRAME_BYTES))
                     ? cfbp_pkg::LEN_W'(cfbp_pkg::FRAME_BYTES) : in_data.load_len;

    cfbp_seq u_seq
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .needs_walk (needs_walk),
        .last_chunk (last_chunk),
        .out_free   (out_free),
        .ctrl       (ctrl)
    );

    cfbp_chunk u_chunk
    (
        .ext        (ext_reg),
        .cursor     (cursor_reg),
        .remaining  (rem_reg),
        .value      (fval_reg),
        .id_data    (id_reg),
        .frame_data (data_reg),
        .chunk      (chunk)
    );

    always_comb
    begin
        ext_next       = cfg_we ? cfg_wdata : ext_reg;
        id_next        = id_reg;
        data_next      = data_reg;
        len_next       = len_reg;
        cursor_next    = cursor_reg;
        out_valid_next = out_valid_reg;
        kind_next      = kind_reg;
        fval_next      = fval_reg;
        rem_next       = rem_reg;
        acc_next       = acc_reg;
        ovf_next       = ovf_reg;
        out_next       = out_reg;

        if (accept)
        begin
            kind_next = in_data.kind;
            fval_next = in_data.field_value;
            rem_next  = in_data.bit_count;
            acc_next  = '0;
            ovf_next  = ovf;
            case (in_data.kind)
                cfbp_pkg::KIND_REWIND:
                begin
                    cursor_next = '0;
                end
                cfbp_pkg::KIND_LOAD:
                begin
                    id_next     = in_data.load_id;
                    data_next   = in_data.load_data;
                    len_next    = load_len;
                    cursor_next = '0;
                end
                default:
                begin
                    cursor_next = cursor_reg;
                end
            endcase
        end

        if (ctrl.walk_en)
        begin
            if (kind_reg == cfbp_pkg::KIND_WRITE)
            begin
                if (chunk.in_id)
                begin
                    id_next = chunk.new_unit;
                end
                else
                begin
                    data_next[{~chunk.byte_idx, 3'b000} +: 8] = chunk.new_unit[7:0];
                end
                if (last_chunk)
                begin
                    len_next = write_len;
                end
            end
            else
            begin
                acc_next = acc_reg | chunk.read_bits;
            end
            cursor_next = new_cursor;
            rem_next    = rem_reg - chunk.take;
        end

        if (ctrl.finish)
        begin
            out_next.read_value = acc_reg;
            out_next.frame_id   = id_reg;
            out_next.frame_data = data_reg;
            out_next.frame_len  = len_reg;
            out_next.bits_used  = cursor_reg;
            out_next.overflow   = ovf_reg;
            out_valid_next      = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_reg       <= 1'b0;
            id_reg        <= '0;
            data_reg      <= '0;
            len_reg       <= '0;
            cursor_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ext_reg       <= ext_next;
            id_reg        <= id_next;
            data_reg      <= data_next;
            len_reg       <= len_next;
            cursor_reg    <= cursor_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        fval_reg <= fval_next;
        rem_reg  <= rem_next;
        acc_reg  <= acc_next;
        ovf_reg  <= ovf_next;
        out_reg  <= out_next;
    end

    assign in_ready  = ctrl.in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== hdl/cfbp_checker.sv =====
// port-level checks for the can frame bit packer, bound to the top level
// depends on cfbp_pkg and can_frame_bit_packer_unit
module cfbp_checker
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input cfbp_pkg::out_word_t out_data
);

    // a held result word stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output word changed while stalled");

    // one word at a time
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken on back-to-back cycles");

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.frame_len <= 4'(cfbp_pkg::FRAME_BYTES))
        else $error("frame length out of range");

    // a rejected request reads nothing
    a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.overflow |-> out_data.read_value == '0)
        else $error("read value set on overflow");

endmodule

bind can_frame_bit_packer_unit cfbp_checker u_cfbp_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
